// ----- hw/rtl/msscan_pkg.sv -----
// Shared types and constants for the masked byte signature scanner.
package msscan_pkg;

    localparam int PAT_WORDS = 4;
    localparam int PAT_BYTES = 8 * PAT_WORDS;
    localparam int PAT_BITS  = 8 * PAT_BYTES;
    localparam int CARE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int ADDR_W    = 29;
    localparam int SEEN_W    = 30;
    localparam int CNT_W     = 16;
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;

    localparam logic [SEEN_W-1:0] SEEN_MAX  = 30'h3FFF_FFFF;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 16'hFFFF;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_PAT0   = 3'd0,
        REG_PAT1   = 3'd1,
        REG_PAT2   = 3'd2,
        REG_PAT3   = 3'd3,
        REG_CARE   = 3'd4,
        REG_LENGTH = 3'd5,
        REG_BASE   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [PAT_BITS-1:0] pattern;
        logic [CARE_W-1:0]   care;
        logic [LEN_W-1:0]    length;
        logic [ADDR_W-1:0]   base;
    } t_cfg;

    // one classified byte handed from front to back
    typedef struct packed {
        logic              hit;
        logic [SEEN_W-1:0] offset;
        logic              last;
        t_status           status;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hw/rtl/msscan_cfg.sv -----
// APB register file holding pattern, care mask, length and region base.
module msscan_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msscan_pkg::APB_AW-1:0] paddr,
    input  logic [msscan_pkg::APB_DW-1:0] pwdata,
    output logic [msscan_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output msscan_pkg::t_cfg             o_cfg
);
    import msscan_pkg::*;

    logic [63:0]       r_pat [PAT_WORDS];
    logic [CARE_W-1:0] r_care;
    logic [LEN_W-1:0]  r_length;
    logic [ADDR_W-1:0] r_base;
    t_reg_idx          idx;
    logic              wr_en;

    assign idx   = t_reg_idx'(paddr[5:3]);
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAT_WORDS; k++) r_pat[k] <= '0;
            r_care   <= '0;
            r_length <= '0;
            r_base   <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_PAT0:   r_pat[0] <= pwdata;
                REG_PAT1:   r_pat[1] <= pwdata;
                REG_PAT2:   r_pat[2] <= pwdata;
                REG_PAT3:   r_pat[3] <= pwdata;
                REG_CARE:   r_care   <= pwdata[CARE_W-1:0];
                REG_LENGTH: r_length <= pwdata[LEN_W-1:0];
                REG_BASE:   r_base   <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PAT0:   prdata = r_pat[0];
            REG_PAT1:   prdata = r_pat[1];
            REG_PAT2:   prdata = r_pat[2];
            REG_PAT3:   prdata = r_pat[3];
            REG_CARE:   prdata = APB_DW'(r_care);
            REG_LENGTH: prdata = APB_DW'(r_length);
            REG_BASE:   prdata = APB_DW'(r_base);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.pattern = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};
    assign o_cfg.care    = r_care;
    assign o_cfg.length  = r_length;
    assign o_cfg.base    = r_base;

endmodule

// ----- hw/rtl/msscan_front.sv -----
// Front end: shifts bytes into the window and classifies each window position.
module msscan_front #(
    parameter int PATTERN_MAX = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msscan_pkg::t_cfg   i_cfg,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output msscan_pkg::t_item  o_item
);
    import msscan_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0]        r_win [PATTERN_MAX];
    logic [7:0]        n_win [PATTERN_MAX];
    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    logic [LW-1:0]     eff_len;
    logic              care_any;
    logic              all_ok;

    assign eff_len = (i_cfg.length > LEN_W'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
                                                          : LW'(i_cfg.length);
    assign n_seen  = (r_seen == SEEN_MAX) ? r_seen : r_seen + SEEN_W'(1);

    always_comb begin
        n_win[0] = i_data_byte;
        for (int j = 1; j < PATTERN_MAX; j++) n_win[j] = r_win[j-1];
    end

    // position 0 of the window is the newest byte; pattern byte i sits at eff_len-1-i
    always_comb begin
        logic          active;
        logic [LW-1:0] d;
        logic [IW-1:0] widx;
        care_any = 1'b0;
        all_ok   = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            active   = (LW'(i) < eff_len) && i_cfg.care[i];
            d        = eff_len - LW'(1) - LW'(i);
            widx     = d[IW-1:0];
            care_any = care_any | active;
            if (active && (n_win[widx] != i_cfg.pattern[8*i +: 8])) all_ok = 1'b0;
        end
    end

    always_comb begin
        o_item.hit    = (eff_len != '0) && care_any && (n_seen >= SEEN_W'(eff_len)) && all_ok;
        o_item.offset = n_seen - SEEN_W'(eff_len);
        o_item.last   = i_last_byte;
        if (eff_len == '0)                  o_item.status = ST_EMPTY;
        else if (n_seen < SEEN_W'(eff_len)) o_item.status = ST_SHORT;
        else if (!care_any)                 o_item.status = ST_EMPTY;
        else                                o_item.status = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_accept) begin
            r_seen <= i_last_byte ? '0 : n_seen;
        end
    end

    // window bytes are only compared once bytes_seen covers them
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int j = 0; j < PATTERN_MAX; j++) r_win[j] <= n_win[j];
        end
    end

endmodule

// ----- hw/rtl/msscan_fifo.sv -----
// Short queue of classified bytes between front and back.
module msscan_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  msscan_pkg::t_item      i_item,
    input  logic                   i_pop,
    output msscan_pkg::t_item      o_item,
    output msscan_pkg::t_q_status  o_status
);
    import msscan_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_PW-1:0] r_wr;
    logic [Q_PW-1:0] r_rd;
    logic [Q_CW-1:0] r_cnt;

    assign o_status.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_item         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + Q_PW'(1);
            if (i_pop)  r_rd <= r_rd + Q_PW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

// ----- hw/rtl/msscan_back.sv -----
// Back end: counts hits, keeps the first offset and builds the region result.
module msscan_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [msscan_pkg::ADDR_W-1:0]     i_base,
    input  msscan_pkg::t_q_status             i_q_status,
    input  msscan_pkg::t_item                 i_item,
    output logic                              o_pop,
    output logic                              o_res_valid,
    input  logic                              i_res_stall,
    output logic [msscan_pkg::CNT_W-1:0]      o_match_count,
    output logic [msscan_pkg::ADDR_W-1:0]     o_first_match_address,
    output logic                              o_unique_found,
    output logic [1:0]                        o_scan_status
);
    import msscan_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [SEEN_W-1:0] r_first;
    logic [CNT_W-1:0]  n_count;
    logic [SEEN_W-1:0] n_first;
    logic              r_out_valid;
    logic              out_free;
    logic              emit;

    assign out_free = !r_out_valid || !i_res_stall;
    // a last-byte transfer waits for room in the output register
    assign o_pop    = !i_q_status.empty && (!i_item.last || out_free);
    assign emit     = o_pop && i_item.last;

    always_comb begin
        n_count = r_count;
        n_first = r_first;
        if (i_item.hit) begin
            if (r_count != COUNT_MAX) n_count = r_count + CNT_W'(1);
            if (r_count == '0)        n_first = i_item.offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count <= i_item.last ? '0 : n_count;
                r_first <= i_item.last ? '0 : n_first;
            end
            if (emit)          r_out_valid <= 1'b1;
            else if (out_free) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_scan_status <= i_item.status;
            if (i_item.status == ST_OK) begin
                o_match_count         <= n_count;
                o_first_match_address <= (n_count != '0) ? i_base + n_first[ADDR_W-1:0]
                                                         : '0;
                o_unique_found        <= (n_count == CNT_W'(1));
            end else begin
                o_match_count         <= '0;
                o_first_match_address <= '0;
                o_unique_found        <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;

endmodule

// ----- hw/rtl/masked_byte_signature_scanner_core.sv -----
// Result: the last byte's item is queued, then popped into the registered result outputs after any items ahead.
// Throughput: one byte per cycle while the queue is not full, using a combinational window compare in the front end.
// A four-entry queue lets the front keep taking bytes while a result waits downstream.
// Reset: synchronous, active low; clears config, counters, valid flag and queue pointers, no clearing pass.
// Window contents are not reset; only bytes of the current region can ever produce a hit.
module masked_byte_signature_scanner_core #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msscan_pkg::APB_AW-1:0]     paddr,
    input  logic [msscan_pkg::APB_DW-1:0]     pwdata,
    output logic [msscan_pkg::APB_DW-1:0]     prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_res_valid,
    input  logic                              i_res_stall,
    output logic [msscan_pkg::CNT_W-1:0]      o_match_count,
    output logic [msscan_pkg::ADDR_W-1:0]     o_first_match_address,
    output logic                              o_unique_found,
    output logic [1:0]                        o_scan_status
);
    import msscan_pkg::*;

    t_cfg      cfg;
    t_item     front_item;
    t_item     head_item;
    t_q_status q_status;
    logic      in_accept;
    logic      pop;

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    msscan_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    msscan_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_item      (front_item)
    );

    msscan_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    msscan_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_base                (cfg.base),
        .i_q_status            (q_status),
        .i_item                (head_item),
        .o_pop                 (pop),
        .o_res_valid           (o_res_valid),
        .i_res_stall           (i_res_stall),
        .o_match_count         (o_match_count),
        .o_first_match_address (o_first_match_address),
        .o_unique_found        (o_unique_found),
        .o_scan_status         (o_scan_status)
    );

    a_bad_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_scan_status != ST_OK) |->
            (o_match_count == '0) && (o_first_match_address == '0) && !o_unique_found)
        else $error("nonzero status with nonzero result fields");

    a_unique_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_unique_found |-> (o_match_count == CNT_W'(1)))
        else $error("unique flag without exactly one match");

    a_no_match_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_match_count == '0) |-> (o_first_match_address == '0))
        else $error("first match address set without a match");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

endmodule
